// ===== hw/rtl/rld_pkg.sv =====
// Shared types and constants of the RMS level detector.
package rld_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int MS_W       = 31;
    localparam int LEVEL_W    = 16;
    localparam int RAD_W      = 32;
    localparam int REM_W      = 17;
    localparam int ROOT_STEPS = LEVEL_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_STEPS - 1);

    typedef struct packed {
        logic load_sample;
        logic square;
        logic scale;
        logic update;
        logic root_step;
        logic load_out;
    } rld_cmd_t;

endpackage

// ===== hw/rtl/rms_level_detector_unit.sv =====
// Top level of the one-pole RMS level detector.
//
// Input channel s_valid/s_ready/s_sample carries one signed 16-bit sample per
// transaction. Output channel m_valid/m_ready/m_rms_level returns one unsigned
// 16-bit level per sample: floor(sqrt(ms)), ms = (a*ms + (65536-a)*x*x) >> 16.
// cfg_valid/cfg_ready/cfg_data writes the 16-bit Q0.16 coefficient a;
// cfg_ready is always high. Write it only while no sample is in flight.
// Each sample passes through square, scale, update, 16 root steps and the
// output load, then shows on m_valid. The root unit retires two radicand bits
// per cycle, one root bit per step. A new sample is taken in the cycle after
// the result is loaded, so a sample is accepted only once the previous one is
// through the root steps and loaded.
// When the receiver stalls, the result holds in the output register and the
// next sample is still accepted and worked; it waits before the output load
// until the held result is taken.
// Reset (aresetn low, synchronous) clears the mean square, the coefficient
// and all handshake state.
module rms_level_detector_unit
    import rld_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [COEF_W-1:0]          cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LEVEL_W-1:0]         m_rms_level
);

    rld_cmd_t cmd;

    assign cfg_ready = 1'b1;

    rld_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rld_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_sample    (s_sample),
        .m_rms_level (m_rms_level)
    );

endmodule

// ===== hw/rtl/rld_datapath.sv =====
// Datapath: square, one-pole smoothing update, iterative square root, output register.
module rld_datapath
    import rld_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rld_cmd_t                  cmd,
    input  logic                      cfg_valid,
    input  logic [COEF_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic [LEVEL_W-1:0]        m_rms_level
);

    logic [COEF_W-1:0]         coef_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [MS_W-1:0]           sq_reg;
    logic signed [48:0]        prod_reg;
    logic [MS_W-1:0]           ms_reg;
    logic [MS_W-1:0]           ms_next;
    logic [RAD_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [LEVEL_W-1:0]        root_reg;
    logic [LEVEL_W-1:0]        out_reg;

    logic [SAMPLE_W-1:0]       mag;
    logic [2*SAMPLE_W-1:0]     sq_full;
    logic signed [31:0]        diff;
    logic signed [48:0]        sum;
    logic [REM_W+1:0]          rem_shift;
    logic [REM_W+1:0]          trial;

    assign mag     = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : sample_reg;
    assign sq_full = mag * mag;
    assign diff    = $signed({1'b0, ms_reg}) - $signed({1'b0, sq_reg});
    assign sum     = $signed({2'b00, sq_reg, 16'h0000}) + prod_reg;
    assign ms_next = sum[46:16];

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            ms_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                coef_reg <= cfg_data;
            end
            if (cmd.update) begin
                ms_reg <= ms_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_sample;
        end
        if (cmd.square) begin
            sq_reg <= sq_full[MS_W-1:0];
        end
        if (cmd.scale) begin
            prod_reg <= $signed({1'b0, coef_reg}) * diff;
        end
        if (cmd.update) begin
            rad_reg  <= {1'b0, ms_next};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[LEVEL_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out) begin
            out_reg <= root_reg;
        end
    end

    assign m_rms_level = out_reg;

endmodule

// ===== hw/rtl/rld_controller.sv =====
// Controller: sequences one transaction through the datapath and owns the output valid.
module rld_controller
    import rld_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output rld_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_UPDATE,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SQUARE)
        else $error("accepted transaction did not start");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output overwritten while stalled");
    a_root_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROOT && cnt_reg == LAST_STEP |=> state_reg == ST_FINISH)
        else $error("root iteration count wrong");
    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_sample, cmd.square, cmd.scale, cmd.update,
                  cmd.root_step, cmd.load_out}))
        else $error("overlapping datapath commands");
`endif

endmodule
